// ===== design/kmp_pkg.sv =====
// Shared types, sizes and helpers for the streaming KMP matcher.
package kmp_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int POS_BITS    = 32;
   localparam int IDX_BITS    = $clog2(MAX_PATTERN);
   localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_TEXT    = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        match_found;
      logic [31:0] match_start;
      logic [5:0]  pattern_length;
      logic        pattern_overflow;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } cmd_type;

   // low 32 bits of a position, zero-extended when narrower
   function automatic logic [31:0] pos_to_out(input logic [POS_BITS-1:0] p);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (i < POS_BITS) begin
            r[i] = p[i];
         end
      end
      return r;
   endfunction

   // low 6 bits of a length, zero-extended when narrower
   function automatic logic [5:0] len_to_out(input logic [LEN_BITS-1:0] l);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < 6; i++) begin
         if (i < LEN_BITS) begin
            r[i] = l[i];
         end
      end
      return r;
   endfunction

endpackage

// ===== design/kmp_front.sv =====
// Input side: accepts items, decodes the mode and queues them for the engine.
module kmp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kmp_pkg::req_type req_data,
   output logic             cmd_valid,
   output kmp_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import kmp_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.op        = op_type'(req_data.mode);
      cmd_in.data_byte = req_data.data_byte;
      wr_ptr_in        = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in        = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in           = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== design/kmp_back.sv =====
// Engine: pattern and failure memories, failure-link walk, result register.
module kmp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  kmp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kmp_pkg::rsp_type rsp_data
);
   import kmp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_READ  = 4'b0100,
      ST_CMP   = 4'b1000
   } state_type;

   logic [7:0]          pat_mem  [MAX_PATTERN];
   logic [IDX_BITS-1:0] fail_mem [MAX_PATTERN];
   logic [7:0]          p_q_ff;
   logic [IDX_BITS-1:0] f_q_ff;

   state_type           state_ff, state_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [IDX_BITS-1:0] prog_ff, prog_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [LEN_BITS-1:0] k_ff, k_in;
   op_type              op_ff, op_in;
   logic [7:0]          chr_ff, chr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                out_free, hit, done, we;
   logic [IDX_BITS-1:0] waddr, wfail, p_raddr, f_raddr;
   logic [7:0]          wchr;
   logic [LEN_BITS-1:0] k_next;
   logic [POS_BITS-1:0] start_pos;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hit       = (p_q_ff == chr_ff);
   assign p_raddr   = k_ff[IDX_BITS-1:0];
   assign f_raddr   = (state_ff == ST_IDLE) ? IDX_BITS'(len_ff - LEN_BITS'(1))
                                            : IDX_BITS'(k_ff - LEN_BITS'(1));
   assign start_pos = pos_ff + POS_BITS'(1) - POS_BITS'(len_ff);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      prog_in      = prog_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      op_in        = op_ff;
      chr_in       = chr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      we           = 1'b0;
      waddr        = len_ff[IDX_BITS-1:0];
      wchr         = chr_ff;
      wfail        = '0;
      done         = 1'b0;
      k_next       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               op_in  = cmd.op;
               chr_in = cmd.data_byte;
               case (cmd.op)
                  OP_APPEND: begin
                     if (len_ff == LEN_BITS'(MAX_PATTERN)) begin
                        if (out_free) begin
                           cmd_pop = 1'b1;
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '0;
                           rsp_data_in.pattern_overflow = 1'b1;
                           rsp_data_in.pattern_length   = len_to_out(len_ff);
                        end
                     end else if (len_ff == '0) begin
                        if (out_free) begin
                           cmd_pop = 1'b1;
                           we      = 1'b1;
                           wchr    = cmd.data_byte;
                           len_in  = LEN_BITS'(1);
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '0;
                           rsp_data_in.pattern_length = len_to_out(LEN_BITS'(1));
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_TEXT: begin
                     if (len_ff == '0) begin
                        if (out_free) begin
                           cmd_pop = 1'b1;
                           pos_in  = pos_ff + POS_BITS'(1);
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '0;
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        k_in     = (LEN_BITS'(prog_ff) >= len_ff) ? '0 : LEN_BITS'(prog_ff);
                        state_in = ST_READ;
                     end
                  end
                  OP_CLEAR: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        len_in  = '0;
                        prog_in = '0;
                        pos_in  = '0;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end
                  end
                  OP_RESTART: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        prog_in = '0;
                        pos_in  = '0;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_data_in.pattern_length = len_to_out(len_ff);
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            k_in     = LEN_BITS'(f_q_ff);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (hit) begin
               done   = 1'b1;
               k_next = k_ff + LEN_BITS'(1);
            end else if (k_ff == '0) begin
               done   = 1'b1;
            end else begin
               k_in     = LEN_BITS'(f_q_ff);
               state_in = ST_READ;
            end
            if (done && out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (op_ff == OP_APPEND) begin
                  we     = 1'b1;
                  wfail  = k_next[IDX_BITS-1:0];
                  len_in = len_ff + LEN_BITS'(1);
                  rsp_data_in.pattern_length = len_to_out(len_ff + LEN_BITS'(1));
               end else begin
                  pos_in = pos_ff + POS_BITS'(1);
                  rsp_data_in.pattern_length = len_to_out(len_ff);
                  if (k_next == len_ff) begin
                     prog_in = '0;
                     rsp_data_in.match_found = 1'b1;
                     rsp_data_in.match_start = pos_to_out(start_pos);
                  end else begin
                     prog_in = k_next[IDX_BITS-1:0];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         pat_mem[waddr]  <= wchr;
         fail_mem[waddr] <= wfail;
      end
      p_q_ff <= pat_mem[p_raddr];
      f_q_ff <= fail_mem[f_raddr];
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      op_ff       <= op_in;
      chr_ff      <= chr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         prog_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         prog_ff      <= prog_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/kmp_stream_matcher.sv =====
// Top level of the streaming KMP matcher: front queue, engine, checks.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_ready    req_data  (mode, data_byte)
//   rsp      out        rsp_valid / rsp_ready    rsp_data  (match, start, length, overflow)
//
// Clear, restart, refused appends, the first append and text with no pattern are handled
// in the idle state of the engine.
// Text byte: idle, read, compare; other appends: idle, fetch, read, compare.
// Each failure-link step repeats read and compare; both memories have a registered read.
// Synchronous reset empties the queue, the pattern length, progress and position.
// A 2-item queue lets input flow while the engine or the result register stalls.
module kmp_stream_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kmp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kmp_pkg::rsp_type rsp_data
);
   import kmp_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   kmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   kmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_match_needs_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.match_found |-> rsp_data.pattern_length != '0)
      else $error("match reported with empty pattern");

   a_match_not_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.match_found && rsp_data.pattern_overflow))
      else $error("match and overflow in one item");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.match_found |-> rsp_data.match_start == '0)
      else $error("match_start set without a match");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("engine took from an empty queue");

endmodule

// ===== verif/kmp_match_checker.sv =====
// Checker for the KMP matcher: watches both channels, predicts results and compares them.
module kmp_match_checker
   import kmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned mismatches,
   output int unsigned results_due
);

   logic [7:0]          pat_bytes [MAX_PATTERN];
   int unsigned         border [MAX_PATTERN];
   int unsigned         pat_len;
   int unsigned         progress;
   logic [POS_BITS-1:0] text_pos;
   rsp_type             pending_results [$];

   function automatic rsp_type predict_result(input req_type item);
      rsp_type             r;
      int unsigned         k;
      logic [POS_BITS-1:0] first;
      r = '0;
      case (item.mode)
         OP_APPEND: begin
            if (pat_len >= MAX_PATTERN) begin
               r.pattern_overflow = 1'b1;
            end else begin
               k = 0;
               if (pat_len > 0) begin
                  k = border[pat_len - 1];
                  while (k > 0 && pat_bytes[k] != item.data_byte) k = border[k - 1];
                  if (pat_bytes[k] == item.data_byte) k++;
               end
               pat_bytes[pat_len] = item.data_byte;
               border[pat_len] = k;
               pat_len++;
            end
         end
         OP_TEXT: begin
            if (pat_len > 0) begin
               k = (progress >= pat_len) ? 0 : progress;
               while (k > 0 && pat_bytes[k] != item.data_byte) k = border[k - 1];
               if (pat_bytes[k] == item.data_byte) k++;
               if (k == pat_len) begin
                  first = text_pos + 1'b1 - POS_BITS'(pat_len);
                  r.match_found = 1'b1;
                  r.match_start = 32'(first);
                  k = 0;
               end
               progress = k;
            end
            text_pos = text_pos + 1'b1;
         end
         OP_CLEAR: begin
            pat_len = 0;
            progress = 0;
            text_pos = '0;
         end
         default: begin
            progress = 0;
            text_pos = '0;
         end
      endcase
      r.pattern_length = 6'(pat_len);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            pat_bytes[i] = '0;
            border[i] = 0;
         end
         pat_len = 0;
         progress = 0;
         text_pos = '0;
         pending_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result expected none got 0x%0h", $time, rsp_data);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("match_found", 32'(want.match_found), 32'(rsp_data.match_found));
               check_field("match_start", want.match_start, rsp_data.match_start);
               check_field("pattern_length", 32'(want.pattern_length),
                           32'(rsp_data.pattern_length));
               check_field("pattern_overflow", 32'(want.pattern_overflow),
                           32'(rsp_data.pattern_overflow));
            end
         end
         if (req_valid && req_ready) pending_results.push_back(predict_result(req_data));
      end
      results_due = pending_results.size();
   end

endmodule

// ===== verif/kmp_stream_matcher_test.sv =====
// Testbench top for the KMP matcher: clock, reset, stimulus, flow control and verdict.
module kmp_stream_matcher_test;
   import kmp_pkg::*;

   localparam int HOLD_CYCLES = 120;
   localparam int QUIET_LIMIT = 3000;

   typedef enum logic [2:0] {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_HOLD
   } phase_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int unsigned mismatches;
   int unsigned results_due;
   int unsigned items_sent;
   int unsigned quiet_cycles;
   phase_type   phase;
   bit          held;

   kmp_stream_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   kmp_match_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned idle_pct(input phase_type ph, input bit receiver);
      case (ph)
         PH_SEND_IDLE:  return receiver ? 0 : 63;
         PH_RECV_STALL: return receiver ? 63 : 0;
         PH_BOTH:       return 23;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [7:0] pick_byte(input logic [23:0] letters);
      if ($urandom_range(0, 99) < 8) return 8'($urandom);
      return letters[8 * $urandom_range(0, 2) +: 8];
   endfunction

   task automatic send_item(input op_type op, input logic [7:0] value);
      req_type item;
      item.mode = op;
      item.data_byte = value;
      while ($urandom_range(0, 99) < idle_pct(phase, 1'b0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // maybe clear or restart, build a pattern mostly over a small alphabet, then feed text
   task automatic run_session(input bit full_store);
      logic [23:0] letters;
      logic [7:0]  pat [$];
      int unsigned plen, tlen, n;
      letters = 24'($urandom);
      n = $urandom_range(0, 9);
      if (n < 7) send_item(OP_CLEAR, 8'($urandom));
      else if (n < 9) send_item(OP_RESTART, 8'($urandom));
      if (full_store) plen = 34;
      else if ($urandom_range(0, 11) == 0) plen = $urandom_range(28, 36);
      else plen = $urandom_range(1, 6);
      for (int i = 0; i < plen; i++) begin
         pat.push_back(pick_byte(letters));
         send_item(OP_APPEND, pat[i]);
      end
      tlen = $urandom_range(8, 30);
      for (int i = 0; i < tlen; i++) begin
         n = $urandom_range(0, 99);
         if (n < 15) begin
            foreach (pat[j]) send_item(OP_TEXT, pat[j]);
         end else if (n < 18) begin
            send_item(OP_RESTART, 8'($urandom));
         end else if (n < 21) begin
            pat.push_back(pick_byte(letters));
            send_item(OP_APPEND, pat[pat.size() - 1]);
         end else if (n < 22) begin
            send_item(OP_CLEAR, 8'($urandom));
         end else begin
            send_item(OP_TEXT, pick_byte(letters));
         end
      end
   endtask

   initial begin
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_HOLD && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct(phase, 1'b1));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      phase <= PH_FREE;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty pattern, extreme bytes, non-overlap, append during text, restart, clear
      send_item(OP_TEXT, 8'h00);
      send_item(OP_APPEND, 8'h00);
      send_item(OP_APPEND, 8'hFF);
      send_item(OP_APPEND, 8'h00);
      send_item(OP_TEXT, 8'h00);
      send_item(OP_TEXT, 8'hFF);
      send_item(OP_TEXT, 8'h00);
      send_item(OP_TEXT, 8'hFF);
      send_item(OP_TEXT, 8'h00);
      send_item(OP_APPEND, 8'hFF);
      send_item(OP_TEXT, 8'hFF);
      send_item(OP_TEXT, 8'h00);
      send_item(OP_TEXT, 8'hFF);
      send_item(OP_RESTART, 8'hA5);
      send_item(OP_TEXT, 8'h00);
      send_item(OP_CLEAR, 8'h5A);
      send_item(OP_TEXT, 8'hFF);
      send_item(OP_APPEND, 8'h41);
      send_item(OP_TEXT, 8'h41);
      send_item(OP_TEXT, 8'h41);

      while (items_sent < 220) run_session(1'b0);
      phase <= PH_SEND_IDLE;
      while (items_sent < 420) run_session(1'b0);
      phase <= PH_RECV_STALL;
      while (items_sent < 620) run_session(1'b0);
      phase <= PH_BOTH;
      while (items_sent < 800) run_session(1'b0);
      phase <= PH_HOLD;
      run_session(1'b1);
      phase <= PH_FREE;
      while (items_sent < 900) run_session(1'b0);

      req_valid <= 1'b0;
      while (results_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && results_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== kmp_stream_matcher.f =====
design/kmp_pkg.sv
design/kmp_front.sv
design/kmp_back.sv
design/kmp_stream_matcher.sv
verif/kmp_match_checker.sv
verif/kmp_stream_matcher_test.sv
